// ===== design/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg: shared constants and types of the pinhole ray generator
// Widths, fixed-point formats, register codes and reset values used by the
// top level and by the normaliser pipeline.
// ----------------------------------------------------------------------------
package ppr_pkg;

  // coordinate and fraction formats
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 14;
  localparam int OUT_FRAC   = 14;
  localparam int COL_W      = 12;
  localparam int COORD_USE  = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;
  localparam int FRAC_MAX   = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS : OUT_FRAC;

  // field and register widths
  localparam int WIDTH_W   = 13;
  localparam int RECIP_W   = 24;
  localparam int SCALE_W   = 24;
  localparam int VEC_W     = 48;
  localparam int COMP_W    = 16;
  localparam int DIR_W     = 16;
  localparam int IDX_W     = 24;
  localparam int CFG_IDX_W = 3;

  // normaliser widths
  localparam int NORM_W     = 32;
  localparam int SQ_W       = 2 * NORM_W;
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int ROOT_W     = NORM_W;
  localparam int QB         = FRAC_MAX + 1;
  localparam int QO_W       = FRAC_MAX + 2;
  localparam int REM_W      = NORM_W + FRAC_MAX;

  // register codes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_OVER_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_OVER_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_SCALE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_VECTOR     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UP_VECTOR        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_VECTOR      = 3'd7;

  // reset values
  localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH = 13'd640;
  localparam logic [RECIP_W-1:0] RST_TWO_OVER_W  = 24'd52429;
  localparam logic [RECIP_W-1:0] RST_TWO_OVER_H  = 24'd69905;
  localparam logic [SCALE_W-1:0] RST_H_SCALE     = 24'd65536;
  localparam logic [SCALE_W-1:0] RST_V_SCALE     = 24'd65536;
  localparam logic [VEC_W-1:0]   RST_RIGHT       = 48'h0000_0000_4000;
  localparam logic [VEC_W-1:0]   RST_UP          = 48'h0000_4000_0000;
  localparam logic [VEC_W-1:0]   RST_VIEW        = 48'h4000_0000_0000;

  // pipeline control between stages
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

  typedef logic signed [NORM_W-1:0] norm_t;
  typedef logic signed [QO_W-1:0]   quo_t;
  typedef logic [IDX_W-1:0]         tag_t;

endpackage

// ===== design/ppr_norm.sv =====
// ----------------------------------------------------------------------------
// ppr_norm: pipelined vector normaliser; three signed words n give
// q = round(n * 2^S / isqrt(sum n^2)), rounded half away from zero; S is
// FRAC_BITS or OUT_FRAC. One word enters per cycle while ctl_i.en is high.
// ----------------------------------------------------------------------------
module ppr_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  ppr_pkg::pipe_ctl_t ctl_i,
  input  logic               frac_sel_i,
  input  ppr_pkg::norm_t     n_i [3],
  input  ppr_pkg::tag_t      tag_i,
  output logic               valid_o,
  output ppr_pkg::quo_t      q_o [3],
  output ppr_pkg::tag_t      tag_o
);

  localparam int NW  = ppr_pkg::NORM_W;
  localparam int SW  = ppr_pkg::SQ_W;
  localparam int RS  = ppr_pkg::ROOT_STEPS;
  localparam int RW  = ppr_pkg::ROOT_W;
  localparam int QB  = ppr_pkg::QB;
  localparam int RMW = ppr_pkg::REM_W;
  localparam ppr_pkg::quo_t Q_LIM = ppr_pkg::quo_t'(1) << ppr_pkg::FRAC_MAX;

  // magnitudes of the incoming word
  logic [NW-1:0] mag_in [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_in[k] = n_i[k][NW-1] ? NW'(-n_i[k]) : NW'(n_i[k]);
    end
  end

  // squares
  logic [SW-1:0]  sq_r [3];
  ppr_pkg::norm_t sq_n_r [3];
  ppr_pkg::tag_t  sq_tag_r;
  logic           sq_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else if (ctl_i.en) begin
      sq_v_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= SW'(mag_in[k]) * SW'(mag_in[k]);
      end
      sq_n_r   <= n_i;
      sq_tag_r <= tag_i;
    end
  end

  // square root pipeline, one result bit per stage
  logic [SW-1:0]  rt_rem_r  [RS+1];
  logic [SW-1:0]  rt_root_r [RS+1];
  ppr_pkg::norm_t rt_n_r    [RS+1][3];
  ppr_pkg::tag_t  rt_tag_r  [RS+1];
  logic           rt_v_r    [RS+1];

  // sum of squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_v_r[0] <= 1'b0;
    end else if (ctl_i.en) begin
      rt_v_r[0] <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      rt_rem_r[0]  <= sq_r[0] + sq_r[1] + sq_r[2];
      rt_root_r[0] <= '0;
      rt_n_r[0]    <= sq_n_r;
      rt_tag_r[0]  <= sq_tag_r;
    end
  end

  for (genvar s = 1; s <= RS; s++) begin : g_root
    localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 * s);
    logic [SW-1:0] trial;
    assign trial = rt_root_r[s-1] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_v_r[s] <= 1'b0;
      end else if (ctl_i.en) begin
        rt_v_r[s] <= rt_v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        if (rt_rem_r[s-1] >= trial) begin
          rt_rem_r[s]  <= rt_rem_r[s-1] - trial;
          rt_root_r[s] <= (rt_root_r[s-1] >> 1) + BIT;
        end else begin
          rt_rem_r[s]  <= rt_rem_r[s-1];
          rt_root_r[s] <= rt_root_r[s-1] >> 1;
        end
        rt_n_r[s]   <= rt_n_r[s-1];
        rt_tag_r[s] <= rt_tag_r[s-1];
      end
    end
  end

  // dividend set-up: scaled magnitude plus half the length
  logic [RW-1:0]  len;
  logic [NW-1:0]  mag_rt [3];
  logic [RMW-1:0] num_nxt [3];
  assign len = rt_root_r[RS][RW-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_rt[k]  = rt_n_r[RS][k][NW-1] ? NW'(-rt_n_r[RS][k]) : NW'(rt_n_r[RS][k]);
      num_nxt[k] = (frac_sel_i ? (RMW'(mag_rt[k]) << ppr_pkg::OUT_FRAC)
                               : (RMW'(mag_rt[k]) << ppr_pkg::FRAC_BITS))
                   + RMW'(len >> 1);
    end
  end

  // restoring divider, one quotient bit per stage
  logic [RMW-1:0] dv_rem_r [QB+1][3];
  logic [QB-1:0]  dv_q_r   [QB+1][3];
  logic           dv_neg_r [QB+1][3];
  logic [RW-1:0]  dv_den_r [QB+1];
  ppr_pkg::tag_t  dv_tag_r [QB+1];
  logic           dv_v_r   [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (ctl_i.en) begin
      dv_v_r[0] <= rt_v_r[RS];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      for (int k = 0; k < 3; k++) begin
        dv_rem_r[0][k] <= num_nxt[k];
        dv_q_r[0][k]   <= '0;
        dv_neg_r[0][k] <= rt_n_r[RS][k][NW-1];
      end
      dv_den_r[0] <= len;
      dv_tag_r[0] <= rt_tag_r[RS];
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_div
    localparam int SH = QB - j;
    logic [RMW-1:0] trial;
    assign trial = RMW'(dv_den_r[j-1]) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (ctl_i.en) begin
        dv_v_r[j] <= dv_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        for (int k = 0; k < 3; k++) begin
          if (dv_rem_r[j-1][k] >= trial) begin
            dv_rem_r[j][k] <= dv_rem_r[j-1][k] - trial;
            dv_q_r[j][k]   <= dv_q_r[j-1][k] | (QB'(1) << SH);
          end else begin
            dv_rem_r[j][k] <= dv_rem_r[j-1][k];
            dv_q_r[j][k]   <= dv_q_r[j-1][k];
          end
          dv_neg_r[j][k] <= dv_neg_r[j-1][k];
        end
        dv_den_r[j] <= dv_den_r[j-1];
        dv_tag_r[j] <= dv_tag_r[j-1];
      end
    end
  end

  // sign and zero-length guard
  ppr_pkg::quo_t q_pos [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q_pos[k] = $signed({1'b0, dv_q_r[QB][k]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (ctl_i.en) begin
      valid_o <= dv_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      for (int k = 0; k < 3; k++) begin
        if (dv_den_r[QB] == '0) begin
          q_o[k] <= '0;
        end else begin
          q_o[k] <= dv_neg_r[QB][k] ? -q_pos[k] : q_pos[k];
        end
      end
      tag_o <= dv_tag_r[QB];
    end
  end

  // a normalised component never exceeds one in magnitude
  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_o |-> (q_o[0] <= Q_LIM) && (q_o[0] >= -Q_LIM) &&
                (q_o[1] <= Q_LIM) && (q_o[1] >= -Q_LIM) &&
                (q_o[2] <= Q_LIM) && (q_o[2] >= -Q_LIM))
    else $error("normaliser output out of range");

endmodule

// ===== design/pinhole_primary_ray_generator_unit.sv =====
// ----------------------------------------------------------------------------
// pinhole_primary_ray_generator_unit: primary ray directions for a pinhole camera
// Pixel column and row in, unit world-space ray direction (Q1.14) and linear
// pixel index out.
// ----------------------------------------------------------------------------
// Usage
//   in_*   : one pixel word per handshake (in_valid / in_ready)
//   out_*  : one ray word per pixel, same order (out_valid / out_ready)
//   cfg_*  : register writes by index, always ready; write only while the
//            pipeline is empty
// Throughput is one pixel per cycle while in_ready is high; the pipeline
// depth comes from two normalisers, each a 32-stage square root followed by
// a restoring divider with one quotient bit per stage.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// camera: 640 pixels per row, x right, y up, z forward, unit scales.
// When the receiver stalls the output word holds and one more word goes into
// a skid register; in_ready then drops and the whole pipeline freezes, so
// nothing is lost or repeated. in_ready is a register output.
// ----------------------------------------------------------------------------
module pinhole_primary_ray_generator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_pixel_col,
  input  logic [11:0] in_pixel_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic signed [15:0] out_dir_z,
  output logic [23:0] out_pixel_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int CU     = ppr_pkg::COORD_USE;
  localparam int PA_W   = CU + 1 + ppr_pkg::RECIP_W;
  localparam int AR_W   = PA_W + 2;
  localparam int A_W    = 35;
  localparam int MA_W   = A_W + ppr_pkg::SCALE_W + 1;
  localparam int IDXP_W = CU + ppr_pkg::WIDTH_W;
  localparam int NW     = ppr_pkg::NORM_W;
  localparam int C_W    = ppr_pkg::FRAC_BITS + 2;
  localparam int PROD_W = C_W + ppr_pkg::COMP_W;
  localparam int CW     = ppr_pkg::COMP_W;
  localparam int DW     = ppr_pkg::DIR_W;

  localparam logic signed [AR_W-1:0] ONE25 = AR_W'(1) << 25;
  localparam logic signed [AR_W-1:0] A_LIM = AR_W'(1) << 33;
  localparam logic [MA_W-1:0]        HALF17 = MA_W'(1) << 16;
  localparam logic [NW-1:0]          U_MAX = (NW'(1) << (NW - 1)) - NW'(1);
  localparam logic [PROD_W-1:0]      HALF10 = PROD_W'(1) << 9;
  localparam ppr_pkg::norm_t         NEG_ONE = -(ppr_pkg::norm_t'(1) << 24);
  localparam logic signed [DW-1:0]   DIR_LIM = DW'(16384);

  typedef struct packed {
    logic signed [DW-1:0] dir_x;
    logic signed [DW-1:0] dir_y;
    logic signed [DW-1:0] dir_z;
    logic [ppr_pkg::IDX_W-1:0] idx;
  } res_t;

  // configuration registers
  logic [ppr_pkg::WIDTH_W-1:0] width_r;
  logic [ppr_pkg::RECIP_W-1:0] tow_r;
  logic [ppr_pkg::RECIP_W-1:0] toh_r;
  logic [ppr_pkg::SCALE_W-1:0] hs_r;
  logic [ppr_pkg::SCALE_W-1:0] vs_r;
  logic [ppr_pkg::VEC_W-1:0]   basis_r [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= ppr_pkg::RST_IMAGE_WIDTH;
      tow_r      <= ppr_pkg::RST_TWO_OVER_W;
      toh_r      <= ppr_pkg::RST_TWO_OVER_H;
      hs_r       <= ppr_pkg::RST_H_SCALE;
      vs_r       <= ppr_pkg::RST_V_SCALE;
      basis_r[0] <= ppr_pkg::RST_RIGHT;
      basis_r[1] <= ppr_pkg::RST_UP;
      basis_r[2] <= ppr_pkg::RST_VIEW;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppr_pkg::REG_IMAGE_WIDTH:      width_r    <= cfg_data[ppr_pkg::WIDTH_W-1:0];
        ppr_pkg::REG_TWO_OVER_WIDTH:   tow_r      <= cfg_data[ppr_pkg::RECIP_W-1:0];
        ppr_pkg::REG_TWO_OVER_HEIGHT:  toh_r      <= cfg_data[ppr_pkg::RECIP_W-1:0];
        ppr_pkg::REG_HORIZONTAL_SCALE: hs_r       <= cfg_data[ppr_pkg::SCALE_W-1:0];
        ppr_pkg::REG_VERTICAL_SCALE:   vs_r       <= cfg_data[ppr_pkg::SCALE_W-1:0];
        ppr_pkg::REG_RIGHT_VECTOR:     basis_r[0] <= cfg_data[ppr_pkg::VEC_W-1:0];
        ppr_pkg::REG_UP_VECTOR:        basis_r[1] <= cfg_data[ppr_pkg::VEC_W-1:0];
        ppr_pkg::REG_VIEW_VECTOR:      basis_r[2] <= cfg_data[ppr_pkg::VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline enable: frozen only while the skid register is full
  logic skid_v_r;
  logic en;
  assign en       = !skid_v_r;
  assign in_ready = en;

  // stage 1: (2x+1)*2/W, (2y+1)*2/H and row times width
  logic [CU-1:0]     x_in;
  logic [CU-1:0]     y_in;
  logic [PA_W-1:0]   s1_p_r [2];
  logic [IDXP_W-1:0] s1_idxp_r;
  logic [CU-1:0]     s1_x_r;
  logic              s1_v_r;

  assign x_in = in_pixel_col[CU-1:0];
  assign y_in = in_pixel_row[CU-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p_r[0] <= PA_W'({x_in, 1'b1}) * PA_W'(tow_r);
      s1_p_r[1] <= PA_W'({y_in, 1'b1}) * PA_W'(toh_r);
      s1_idxp_r <= IDXP_W'(y_in) * IDXP_W'(width_r);
      s1_x_r    <= x_in;
    end
  end

  // stage 2: centre the offsets and saturate
  logic signed [AR_W-1:0] ab_raw [2];
  logic signed [A_W-1:0]  ab_nxt [2];
  logic signed [A_W-1:0]  s2_ab_r [2];
  logic [ppr_pkg::IDX_W-1:0] s2_idx_r;
  logic s2_v_r;

  always_comb begin
    ab_raw[0] = $signed({2'b00, s1_p_r[0]}) - ONE25;
    ab_raw[1] = ONE25 - $signed({2'b00, s1_p_r[1]});
    for (int k = 0; k < 2; k++) begin
      if (ab_raw[k] > A_LIM) begin
        ab_nxt[k] = A_W'(A_LIM);
      end else if (ab_raw[k] < -A_LIM) begin
        ab_nxt[k] = A_W'(-A_LIM);
      end else begin
        ab_nxt[k] = A_W'(ab_raw[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ab_r  <= ab_nxt;
      s2_idx_r <= ppr_pkg::IDX_W'(s1_idxp_r + IDXP_W'(s1_x_r));
    end
  end

  // stage 3: apply the plane scales
  logic signed [MA_W-1:0] s3_ma_r [2];
  logic [ppr_pkg::IDX_W-1:0] s3_idx_r;
  logic s3_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ma_r[0] <= s2_ab_r[0] * $signed({1'b0, hs_r});
      s3_ma_r[1] <= s2_ab_r[1] * $signed({1'b0, vs_r});
      s3_idx_r   <= s2_idx_r;
    end
  end

  // stage 4: round to Q.24 and saturate
  logic [MA_W-1:0] ma_mag [2];
  logic [MA_W-1:0] ma_q [2];
  logic [NW-1:0]   uv_sat [2];
  ppr_pkg::norm_t  s4_uv_r [2];
  logic [ppr_pkg::IDX_W-1:0] s4_idx_r;
  logic s4_v_r;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      ma_mag[k] = s3_ma_r[k][MA_W-1] ? MA_W'(-s3_ma_r[k]) : MA_W'(s3_ma_r[k]);
      ma_q[k]   = (ma_mag[k] + HALF17) >> 17;
      uv_sat[k] = (ma_q[k] > MA_W'(U_MAX)) ? U_MAX : ma_q[k][NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        s4_uv_r[k] <= s3_ma_r[k][MA_W-1] ? -$signed(uv_sat[k]) : $signed(uv_sat[k]);
      end
      s4_idx_r <= s3_idx_r;
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // camera-space normalisation of (u, v, -1)
  ppr_pkg::pipe_ctl_t ctl1;
  ppr_pkg::norm_t     n1_in [3];
  ppr_pkg::quo_t      n1_q [3];
  ppr_pkg::tag_t      n1_tag;
  logic               n1_v;

  assign ctl1.en    = en;
  assign ctl1.valid = s4_v_r;
  assign n1_in[0]   = s4_uv_r[0];
  assign n1_in[1]   = s4_uv_r[1];
  assign n1_in[2]   = NEG_ONE;

  ppr_norm u_norm_cam (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl1),
    .frac_sel_i (1'b0),
    .n_i        (n1_in),
    .tag_i      (s4_idx_r),
    .valid_o    (n1_v),
    .q_o        (n1_q),
    .tag_o      (n1_tag)
  );

  // stage 5: basis products, world axis k by basis vector j
  logic signed [PROD_W-1:0] s5_p_r [3][3];
  ppr_pkg::tag_t s5_idx_r;
  logic s5_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          s5_p_r[k][j] <= $signed(n1_q[j][C_W-1:0]) * $signed(basis_r[j][CW*k +: CW]);
        end
      end
      s5_idx_r <= n1_tag;
    end
  end

  // stage 6: right plus up minus back-scaled view
  logic signed [PROD_W-1:0] s6_acc_r [3];
  ppr_pkg::tag_t s6_idx_r;
  logic s6_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s6_acc_r[k] <= s5_p_r[k][0] + s5_p_r[k][1] - s5_p_r[k][2];
      end
      s6_idx_r <= s5_idx_r;
    end
  end

  // stage 7: round off ten fraction bits
  logic [PROD_W-1:0] acc_mag [3];
  logic [PROD_W-1:0] acc_q [3];
  ppr_pkg::norm_t    s7_w_r [3];
  ppr_pkg::tag_t     s7_idx_r;
  logic              s7_v_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_mag[k] = s6_acc_r[k][PROD_W-1] ? PROD_W'(-s6_acc_r[k]) : PROD_W'(s6_acc_r[k]);
      acc_q[k]   = (acc_mag[k] + HALF10) >> 10;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s7_w_r[k] <= s6_acc_r[k][PROD_W-1] ? -$signed(acc_q[k][NW-1:0])
                                           : $signed(acc_q[k][NW-1:0]);
      end
      s7_idx_r <= s6_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= n1_v;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  // world-space normalisation
  ppr_pkg::pipe_ctl_t ctl2;
  ppr_pkg::quo_t      n2_q [3];
  ppr_pkg::tag_t      n2_tag;
  logic               n2_v;

  assign ctl2.en    = en;
  assign ctl2.valid = s7_v_r;

  ppr_norm u_norm_world (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl2),
    .frac_sel_i (1'b1),
    .n_i        (s7_w_r),
    .tag_i      (s7_idx_r),
    .valid_o    (n2_v),
    .q_o        (n2_q),
    .tag_o      (n2_tag)
  );

  // output register with skid stage
  res_t push_data;
  res_t out_r;
  res_t skid_r;
  logic push;
  logic out_v_r;

  assign push            = en && n2_v;
  assign push_data.dir_x = n2_q[0][DW-1:0];
  assign push_data.dir_y = n2_q[1][DW-1:0];
  assign push_data.dir_z = n2_q[2][DW-1:0];
  assign push_data.idx   = n2_tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      out_r <= skid_v_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

  assign out_valid       = out_v_r;
  assign out_dir_x       = out_r.dir_x;
  assign out_dir_y       = out_r.dir_y;
  assign out_dir_z       = out_r.dir_z;
  assign out_pixel_index = out_r.idx;

  // skid word only exists behind a waiting output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word without output word");

  // skid fills only on a stalled output
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ready))
    else $error("skid filled without stall");

  // delivered direction components are within unit range
  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_x <= DIR_LIM) && (out_dir_x >= -DIR_LIM) &&
                  (out_dir_y <= DIR_LIM) && (out_dir_y >= -DIR_LIM) &&
                  (out_dir_z <= DIR_LIM) && (out_dir_z >= -DIR_LIM))
    else $error("direction component out of range");

endmodule
